// ===== hw/rtl/lshr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lshr_pkg: shared types and constants of the histogram rebinner
// Field widths, command and register codes, the queue entry and helpers.
// ----------------------------------------------------------------------------
package lshr_pkg;

  localparam int ENERGY_W   = 17;
  localparam int COUNT_W    = 32;
  localparam int GE_W       = 10;
  localparam int SUM_W      = 60;
  localparam int BIN_W      = 48;
  localparam int BIN_IDX_W  = 12;   // widest bin index over the supported store depths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_CLEAR = 2'd2
  } lshr_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_WIDTH = 2'd0,
    CFG_PEAK_MODE = 2'd1
  } lshr_cfg_idx_t;

  typedef struct packed {
    logic [GE_W-1:0] bin_width;
    logic            peak_mode;
  } lshr_cfg_t;

  // One decoded command waiting for the back end
  typedef struct packed {
    lshr_cmd_t            cmd;
    logic [BIN_IDX_W-1:0] lo;
    logic [BIN_IDX_W-1:0] top;
    logic                 pnz;
    logic [COUNT_W-1:0]   low_add;
    logic [COUNT_W-1:0]   high_add;
  } lshr_entry_t;

  // Saturating bin add: hold at all ones on overflow
  function automatic logic [BIN_W-1:0] sat_add(input logic [BIN_W-1:0] a,
                                               input logic [COUNT_W-1:0] b);
    logic [BIN_W:0] s;
    s = {1'b0, a} + {{(BIN_W + 1 - COUNT_W){1'b0}}, b};
    return s[BIN_W] ? {BIN_W{1'b1}} : s[BIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/linear_split_histogram_rebinner_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_split_histogram_rebinner_unit: linear-split histogram rebinner
// Splits weighted energies over unit bins and drains them as wider groups.
// ----------------------------------------------------------------------------
// Drain path: a command passes the intake register and the queue; the back end
//   checks its group, walks the stored bins over the bin RAM port, then emits.
// Loads: a read-modify-write on the single bin RAM, of the high bin too when the
//   energy has a fraction; a new command waits until the last one is through.
// Reset and clear: a clearing pass zeroes every bin; input stalls meanwhile,
//   configuration writes are taken at once.
module linear_split_histogram_rebinner_unit #(
  parameter int NUM_BINS  = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [lshr_pkg::ENERGY_W-1:0]   in_energy,
  input  logic [lshr_pkg::COUNT_W-1:0]    in_count_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lshr_pkg::GE_W-1:0]       out_group_energy,
  output logic [lshr_pkg::SUM_W-1:0]      out_group_sum,
  output logic                            out_last_group,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lshr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lshr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lshr_pkg::*;

  lshr_cfg_t   cfg_r, cfg_nxt;
  logic        sweep_busy;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  lshr_entry_t q_wdata;
  lshr_entry_t q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_BIN_WIDTH) begin
        cfg_nxt.bin_width = cfg_data[GE_W-1:0];
      end else if (cfg_index == CFG_PEAK_MODE) begin
        cfg_nxt.peak_mode = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bin_width <= GE_W'(1);
      cfg_r.peak_mode <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lshr_front #(
    .NUM_BINS  (NUM_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_energy   (in_energy),
    .in_count_in (in_count_in),
    .sweep_busy  (sweep_busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  lshr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  lshr_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .sweep_busy       (sweep_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_group_energy (out_group_energy),
    .out_group_sum    (out_group_sum),
    .out_last_group   (out_last_group)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lshr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lshr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lshr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lshr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lshr_front: command intake and decode
// Accepts commands, clamps the energy, splits the count and feeds the queue.
// ----------------------------------------------------------------------------
module lshr_front #(
  parameter int NUM_BINS  = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [lshr_pkg::ENERGY_W-1:0]  in_energy,
  input  logic [lshr_pkg::COUNT_W-1:0]   in_count_in,
  input  logic                           sweep_busy,
  input  logic                           q_full,
  output logic                           q_push,
  output lshr_pkg::lshr_entry_t          q_wdata
);
  import lshr_pkg::*;

  localparam int AW  = $clog2(NUM_BINS);
  localparam int IW  = ENERGY_W - FRAC_BITS;
  localparam int PRW = COUNT_W + FRAC_BITS;

  logic                 accept;
  logic                 keep;
  lshr_cmd_t            cmd_c;
  logic [IW-1:0]        ipart;
  logic [FRAC_BITS-1:0] fpart;
  logic [31:0]          ipart_ext;
  logic                 clamp;
  logic [AW-1:0]        lo_c;
  logic [FRAC_BITS-1:0] p_c;
  logic                 pnz_c;
  logic [AW-1:0]        top_c;
  logic [PRW-1:0]       prod_c;

  logic                 stg_v_r, stg_v_nxt;
  lshr_cmd_t            stg_cmd_r;
  logic [AW-1:0]        stg_lo_r;
  logic [AW-1:0]        stg_top_r;
  logic                 stg_pnz_r;
  logic [COUNT_W-1:0]   stg_count_r;
  logic [COUNT_W-1:0]   stg_high_r;

  assign ipart     = in_energy[ENERGY_W-1:FRAC_BITS];
  assign fpart     = in_energy[FRAC_BITS-1:0];
  assign ipart_ext = 32'(ipart);

  // An energy whose ceiling leaves the store pins to the top bin, no fraction
  assign clamp = (ipart_ext > 32'(NUM_BINS - 1)) ||
                 ((ipart_ext == 32'(NUM_BINS - 1)) && (fpart != '0));
  assign lo_c  = clamp ? AW'(NUM_BINS - 1) : ipart_ext[AW-1:0];
  assign p_c   = clamp ? '0 : fpart;
  assign pnz_c = (p_c != '0);
  assign top_c = lo_c + {{(AW-1){1'b0}}, pnz_c};
  assign prod_c = PRW'(in_count_in) * PRW'(p_c);

  always_comb begin
    keep  = 1'b0;
    cmd_c = CMD_LOAD;
    unique case (in_command)
      CMD_LOAD:  begin keep = 1'b1; cmd_c = CMD_LOAD;  end
      CMD_DRAIN: begin keep = 1'b1; cmd_c = CMD_DRAIN; end
      CMD_CLEAR: begin keep = 1'b1; cmd_c = CMD_CLEAR; end
      default:   keep = 1'b0;  // unused code: drop
    endcase
  end

  assign q_push   = stg_v_r && !q_full;
  assign in_stall = sweep_busy || (stg_v_r && q_full);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (q_push) begin
      stg_v_nxt = 1'b0;
    end
    if (accept && keep) begin
      stg_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      stg_cmd_r   <= cmd_c;
      stg_lo_r    <= lo_c;
      stg_top_r   <= top_c;
      stg_pnz_r   <= pnz_c;
      stg_count_r <= in_count_in;
      stg_high_r  <= prod_c[PRW-1:FRAC_BITS];
    end
  end

  always_comb begin
    q_wdata.cmd      = stg_cmd_r;
    q_wdata.lo       = BIN_IDX_W'(stg_lo_r);
    q_wdata.top      = BIN_IDX_W'(stg_top_r);
    q_wdata.pnz      = stg_pnz_r;
    q_wdata.low_add  = stg_count_r - stg_high_r;
    q_wdata.high_add = stg_high_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lshr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lshr_queue: short command queue
// Register FIFO between the intake and the execution side.
// ----------------------------------------------------------------------------
module lshr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lshr_pkg::lshr_entry_t wdata,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output lshr_pkg::lshr_entry_t rdata
);
  import lshr_pkg::*;

  lshr_entry_t        slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lshr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lshr_back: command execution
// Read-modify-write of bins for loads, bin walks for drains, clearing sweeps.
// ----------------------------------------------------------------------------
module lshr_back #(
  parameter int NUM_BINS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lshr_pkg::lshr_cfg_t         cfg,
  input  logic                        q_valid,
  input  lshr_pkg::lshr_entry_t       q_data,
  output logic                        q_pop,
  output logic                        sweep_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lshr_pkg::GE_W-1:0]   out_group_energy,
  output logic [lshr_pkg::SUM_W-1:0]  out_group_sum,
  output logic                        out_last_group
);
  import lshr_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int KW = $clog2(NUM_BINS + 2);
  localparam int PW = KW + GE_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_LD_LO = 7'b0000100,
    S_LD_HI = 7'b0001000,
    S_DCHK  = 7'b0010000,
    S_DSUM  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } lshr_state_t;

  lshr_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          have_first_r, have_first_nxt;
  logic [AW-1:0] first_top_r, first_top_nxt;
  logic [AW-1:0] last_top_r, last_top_nxt;
  logic [KW-1:0] drain_group_r, drain_group_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [AW-1:0]      ld_lo_r;
  logic [AW-1:0]      ld_top_r;
  logic               ld_pnz_r;
  logic [COUNT_W-1:0] ld_low_r;
  logic [COUNT_W-1:0] ld_high_r;
  logic [PW-1:0]      kw_r;
  logic [GE_W-1:0]    w_r;
  logic [AW-1:0]      dtop_r;
  logic               k_zero_r;
  logic               k_ge2_r;
  logic [AW-1:0]      rd_addr_r;
  logic [AW-1:0]      end_r;
  logic [SUM_W-1:0]   acc_r;
  logic [GE_W-1:0]    out_ge_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_last_r;

  logic [GE_W-1:0] w_c;
  logic [PW-1:0]   kw_c;
  logic [AW-1:0]   top_sel_c;
  logic [PW-1:0]   km1w_c;
  logic [PW-1:0]   start_c;
  logic            skip_c;
  logic            empty_c;
  logic [AW-1:0]   start_idx_c;
  logic [AW-1:0]   end_idx_c;
  logic            out_free;
  logic [AW-1:0]   q_lo;
  logic [AW-1:0]   q_top;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [BIN_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [BIN_W-1:0] ram_rdata;

  lshr_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_lo  = q_data.lo[AW-1:0];
  assign q_top = q_data.top[AW-1:0];

  assign w_c       = (cfg.bin_width == '0) ? GE_W'(1) : cfg.bin_width;
  assign kw_c      = PW'(drain_group_r) * PW'(w_c);
  assign top_sel_c = cfg.peak_mode ? first_top_r : last_top_r;

  assign km1w_c  = kw_r - PW'(w_r);
  assign start_c = km1w_c + PW'(1);
  assign skip_c  = k_ge2_r && (km1w_c > PW'(dtop_r));
  // Group lies wholly past the store: sums to zero
  assign empty_c = !k_zero_r && (start_c > PW'(NUM_BINS - 1));
  assign start_idx_c = k_zero_r ? '0 : start_c[AW-1:0];
  assign end_idx_c   = k_zero_r ? '0 :
                       ((kw_r > PW'(NUM_BINS - 1)) ? LAST_IDX : kw_r[AW-1:0]);

  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_busy = (state_r == S_CLEAR);

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    have_first_nxt  = have_first_r;
    first_top_nxt   = first_top_r;
    last_top_nxt    = last_top_r;
    drain_group_nxt = drain_group_r;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_data.cmd)
            CMD_LOAD: begin
              ram_raddr = q_lo;
              if (!have_first_r) begin
                have_first_nxt = 1'b1;
                first_top_nxt  = q_top;
              end
              last_top_nxt = q_top;
              state_nxt    = S_LD_LO;
            end
            CMD_DRAIN: begin
              state_nxt = S_DCHK;
            end
            CMD_CLEAR: begin
              have_first_nxt  = 1'b0;
              first_top_nxt   = '0;
              last_top_nxt    = '0;
              drain_group_nxt = '0;
              clr_cnt_nxt     = '0;
              state_nxt       = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_LD_LO: begin
        ram_we    = 1'b1;
        ram_waddr = ld_lo_r;
        ram_wdata = sat_add(ram_rdata, ld_low_r);
        if (ld_pnz_r) begin
          ram_raddr = ld_top_r;
          state_nxt = S_LD_HI;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_HI: begin
        ram_we    = 1'b1;
        ram_waddr = ld_top_r;
        ram_wdata = sat_add(ram_rdata, ld_high_r);
        state_nxt = S_IDLE;
      end
      S_DCHK: begin
        if (skip_c) begin
          state_nxt = S_IDLE;  // past the last group: no result
        end else if (empty_c) begin
          state_nxt = S_EMIT;
        end else begin
          ram_raddr = start_idx_c;
          state_nxt = S_DSUM;
        end
      end
      S_DSUM: begin
        if (rd_addr_r == end_r) begin
          state_nxt = S_EMIT;
        end else begin
          ram_raddr = rd_addr_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          drain_group_nxt = drain_group_r + 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      have_first_r  <= 1'b0;
      first_top_r   <= '0;
      last_top_r    <= '0;
      drain_group_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      have_first_r  <= have_first_nxt;
      first_top_r   <= first_top_nxt;
      last_top_r    <= last_top_nxt;
      drain_group_r <= drain_group_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ld_lo_r   <= q_lo;
      ld_top_r  <= q_top;
      ld_pnz_r  <= q_data.pnz;
      ld_low_r  <= q_data.low_add;
      ld_high_r <= q_data.high_add;
      kw_r      <= kw_c;
      w_r       <= w_c;
      dtop_r    <= top_sel_c;
      k_zero_r  <= (drain_group_r == '0);
      k_ge2_r   <= (drain_group_r >= KW'(2));
    end
    if (state_r == S_DCHK) begin
      acc_r     <= '0;
      rd_addr_r <= start_idx_c;
      end_r     <= end_idx_c;
    end
    if (state_r == S_DSUM) begin
      acc_r <= acc_r + {{(SUM_W - BIN_W){1'b0}}, ram_rdata};
      if (rd_addr_r != end_r) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_ge_r   <= kw_r[GE_W-1:0];
      out_sum_r  <= acc_r;
      out_last_r <= (kw_r > PW'(dtop_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_group_energy = out_ge_r;
  assign out_group_sum    = out_sum_r;
  assign out_last_group   = out_last_r;

endmodule
`default_nettype wire

// ===== dv/linear_split_histogram_rebinner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_split_histogram_rebinner_unit_tb: self-checking bench of the rebinner
// Drives loads, drains, clears and unused commands with random gaps on both
// sides, keeps its own histogram model to predict the unpinned drained groups and
// compares each group transfer field by field. Group widths and peak modes
// are changed between runs, at random also in the middle of a drain sequence.
// ----------------------------------------------------------------------------
module linear_split_histogram_rebinner_unit_tb;
  import lshr_pkg::*;

  localparam int NUM_BINS       = 512;
  localparam int FRAC_BITS      = 8;
  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int ITEM_TARGET    = 950;
  localparam int MAX_DRAINS     = 40;
  localparam int SETTLE_CYCLES  = 2000;   // covers queued clears and a full-width walk
  localparam int LONG_HOLD      = 300;
  localparam int QUIET_LIMIT    = 20000;
  localparam int PRESSURE_RUN   = 10;
  localparam int NUM_DIRECTED   = 21;
  localparam int SWEEP_LEN      = 8;
  localparam int ENERGY_CEIL    = (NUM_BINS - 1) << FRAC_BITS;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [BIN_W-1:0] BIN_FULL = '1;

  typedef struct packed {
    logic [GE_W-1:0]  group_energy;
    logic [SUM_W-1:0] group_sum;
    logic             last_group;
  } rebinned_group_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ENERGY_W-1:0] energy;
    logic [COUNT_W-1:0]  count;
    logic                pinned;
    rebinned_group_t     want;
  } directed_row_t;

  localparam rebinned_group_t NO_PIN = '0;

  // Pinned rows carry a group that can be read straight off the bin contents.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b1, '{10'd0, 60'h0, 1'b0}},
    '{CMD_DRAIN, 17'h1FFFF, 32'hFFFFFFFF, 1'b1, '{10'd1, 60'h0, 1'b1}},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_NOP,   17'h00000, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_CLEAR, 17'h1FFFF, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h00000, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h1FFFF, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h00180, 32'h00000100, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h001FF, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b1, '{10'd0, 60'hFFFFFFFF, 1'b0}},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_CLEAR, 17'h00000, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h1FF00, 32'h00000000, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h1FEFF, 32'h12345678, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h10000, 32'h80000000, 1'b0, NO_PIN},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b1, '{10'd0, 60'h0, 1'b0}},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b1, '{10'd1, 60'h0, 1'b0}},
    '{CMD_DRAIN, 17'h00000, 32'h00000000, 1'b1, '{10'd2, 60'h0, 1'b0}},
    '{CMD_NOP,   17'h1FFFF, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{CMD_LOAD,  17'h0007F, 32'hFFFFFFFF, 1'b0, NO_PIN}
  };

  localparam logic [GE_W-1:0] WIDTH_SWEEP [SWEEP_LEN] = '{
    10'd512, 10'd0, 10'd1023, 10'd1, 10'd3, 10'd64, 10'd2, 10'd255
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_command;
  logic [ENERGY_W-1:0]   in_energy;
  logic [COUNT_W-1:0]    in_count_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [GE_W-1:0]       out_group_energy;
  logic [SUM_W-1:0]      out_group_sum;
  logic                  out_last_group;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Histogram model
  logic [BIN_W-1:0] hist_bins [NUM_BINS];
  bit               seen_load;
  int unsigned      first_ceiling;
  int unsigned      last_ceiling;
  int unsigned      next_group;
  logic [GE_W-1:0]  group_width;
  bit               fast_peak;

  rebinned_group_t  pending_groups [$];
  rebinned_group_t  want_group;
  int unsigned      mismatches;
  int unsigned      items_sent;
  int unsigned      quiet_cycles;
  bit               src_burst;
  bit               sink_burst;
  bit               long_hold_req;

  linear_split_histogram_rebinner_unit #(
    .NUM_BINS  (NUM_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_energy        (in_energy),
    .in_count_in      (in_count_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_group_energy (out_group_energy),
    .out_group_sum    (out_group_sum),
    .out_last_group   (out_last_group),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic void clear_histogram();
    foreach (hist_bins[b]) hist_bins[b] = '0;
    seen_load     = 1'b0;
    first_ceiling = 0;
    last_ceiling  = 0;
    next_group    = 0;
  endfunction

  function automatic void add_to_bin(int unsigned idx, logic [63:0] amount);
    logic [63:0] s;
    if (idx >= NUM_BINS) return;
    s = {16'b0, hist_bins[idx]} + amount;
    hist_bins[idx] = (s > {16'b0, BIN_FULL}) ? BIN_FULL : s[BIN_W-1:0];
  endfunction

  function automatic void load_histogram(logic [ENERGY_W-1:0] energy,
                                         logic [COUNT_W-1:0] count);
    int unsigned e;
    int unsigned lo;
    int unsigned frac;
    int unsigned ceil_bin;
    logic [63:0] high;
    e = energy;
    if (e > ENERGY_CEIL) e = ENERGY_CEIL;
    lo       = e >> FRAC_BITS;
    frac     = e & ((1 << FRAC_BITS) - 1);
    ceil_bin = lo + ((frac != 0) ? 1 : 0);
    high     = (64'(count) * 64'(frac)) >> FRAC_BITS;
    add_to_bin(lo, 64'(count) - high);
    if (frac != 0) add_to_bin(ceil_bin, high);
    if (!seen_load) begin
      seen_load     = 1'b1;
      first_ceiling = ceil_bin;
    end
    last_ceiling = ceil_bin;
  endfunction

  function automatic bit groups_exhausted();
    longint unsigned w;
    longint unsigned top;
    w   = (group_width == 0) ? 1 : group_width;
    top = fast_peak ? first_ceiling : last_ceiling;
    return (next_group >= 2) && ((next_group - 1) * w > top);
  endfunction

  function automatic bit next_rebinned_group(output rebinned_group_t g);
    longint unsigned w;
    longint unsigned top;
    longint unsigned k;
    longint unsigned upper;
    longint unsigned sum;
    longint unsigned i;
    g = '0;
    if (groups_exhausted()) return 1'b0;
    w   = (group_width == 0) ? 1 : group_width;
    top = fast_peak ? first_ceiling : last_ceiling;
    k   = next_group;
    sum = 0;
    if (k == 0) begin
      upper = 0;
      sum   = hist_bins[0];
    end else begin
      upper = k * w;
      // bins past the store add nothing
      for (i = (k - 1) * w + 1; i <= upper && i < NUM_BINS; i++) sum += hist_bins[i];
    end
    g.group_energy = upper[GE_W-1:0];
    g.group_sum    = sum[SUM_W-1:0];
    g.last_group   = (upper > top);
    next_group++;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [ENERGY_W-1:0] energy,
                           input logic [COUNT_W-1:0] count, input bit pinned,
                           input rebinned_group_t want);
    int unsigned gap;
    rebinned_group_t got;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_energy   <= energy;
    in_count_in <= count;
    do @(posedge clk); while (in_stall !== 1'b0);
    case (cmd)
      CMD_LOAD:  load_histogram(energy, count);
      CMD_CLEAR: clear_histogram();
      CMD_DRAIN: begin
        if (next_rebinned_group(got)) pending_groups.push_back(pinned ? want : got);
      end
      default: ;
    endcase
    if (cmd != CMD_NOP) items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_BIN_WIDTH: group_width = data;
      CFG_PEAK_MODE: fast_peak = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_groups.size() != 0);
  endtask

  // Registers change only with the block idle: every group out, queued work done.
  task automatic retune(input logic [GE_W-1:0] width, input bit peak);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BIN_WIDTH, width);
    write_reg(CFG_PEAK_MODE, {9'($urandom), peak});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [GE_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 10'd512;
      1:       return GE_W'($urandom_range(0, 1023));
      default: return GE_W'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return COUNT_W'($urandom_range(0, 16'hFFFF));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ENERGY_W-1:0] pick_energy(int unsigned span);
    int unsigned ev;
    int unsigned frac;
    ev   = $urandom_range(0, span);
    frac = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (1 << FRAC_BITS) - 1);
    return ENERGY_W'((ev << FRAC_BITS) | frac);
  endfunction

  // Well-formed run: optional clear, loads within a span of up to 24 groups, then
  // drains until past the last group or MAX_DRAINS, and up to two beyond.
  task automatic histogram_run(input bit pressure);
    int unsigned w_eff;
    int unsigned span;
    int unsigned n_loads;
    int unsigned n;
    int unsigned extra;
    bit          split_drain;
    w_eff = (group_width == 0) ? 1 : group_width;
    span  = w_eff * (pressure ? 24 : $urandom_range(1, 20));
    if (span > NUM_BINS - 1) span = NUM_BINS - 1;
    if (pressure || $urandom_range(0, 3) != 0)
      send_item(CMD_CLEAR, ENERGY_W'($urandom), $urandom, 1'b0, NO_PIN);
    n_loads = $urandom_range(1, 30);
    repeat (n_loads) send_item(CMD_LOAD, pick_energy(span), pick_count(), 1'b0, NO_PIN);
    // hold the sink while drains pile up behind it
    if (pressure) long_hold_req = 1'b1;
    split_drain = !pressure && ($urandom_range(0, 4) == 0);
    n = 0;
    while (!groups_exhausted() && n < MAX_DRAINS) begin
      if (split_drain && n == 2) retune(pick_width(), 1'($urandom));
      send_item(CMD_DRAIN, ENERGY_W'($urandom), $urandom, 1'b0, NO_PIN);
      n++;
    end
    extra = $urandom_range(0, 2);
    repeat (extra) send_item(CMD_DRAIN, ENERGY_W'($urandom), $urandom, 1'b0, NO_PIN);
  endtask

  task automatic noise_run();
    int unsigned n;
    int unsigned pick;
    logic [1:0]  cmd;
    n = $urandom_range(5, 30);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 10)      cmd = CMD_LOAD;
      else if (pick < 17) cmd = CMD_DRAIN;
      else if (pick < 18) cmd = CMD_CLEAR;
      else                cmd = CMD_NOP;
      send_item(cmd, ENERGY_W'($urandom_range(0, 17'h1FFFF)), pick_count(), 1'b0, NO_PIN);
    end
  endtask

  // Compare each group transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_groups.size() == 0) begin
        $error("unexpected group transfer: group_energy %0d group_sum %0h",
               out_group_energy, out_group_sum);
        mismatches++;
      end else begin
        want_group = pending_groups.pop_front();
        if (out_group_energy !== want_group.group_energy) begin
          $error("group_energy: expected %0d, actual %0d",
                 want_group.group_energy, out_group_energy);
          mismatches++;
        end
        if (out_group_sum !== want_group.group_sum) begin
          $error("group_sum: expected %0h, actual %0h", want_group.group_sum, out_group_sum);
          mismatches++;
        end
        if (out_last_group !== want_group.last_group) begin
          $error("last_group: expected %0b, actual %0b",
                 want_group.last_group, out_last_group);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("linear_split_histogram_rebinner_unit_tb failed");
      $finish;
    end
  end

  // Result sink: random hold per transfer, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = sink_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned run;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_LOAD;
    in_energy     = '0;
    in_count_in   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_BIN_WIDTH;
    cfg_data      = '0;
    mismatches    = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    src_burst     = 1'b0;
    sink_burst    = 1'b0;
    long_hold_req = 1'b0;
    clear_histogram();
    group_width = 10'd1;
    fast_peak   = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_DIRECTED; r++)
      send_item(DIRECTED[r].cmd, DIRECTED[r].energy, DIRECTED[r].count,
                DIRECTED[r].pinned, DIRECTED[r].want);

    run = 0;
    while (items_sent < ITEM_TARGET) begin
      if (run == PRESSURE_RUN)
        retune(10'd4, 1'b1);
      else if (run < SWEEP_LEN)
        retune(WIDTH_SWEEP[run], run[0]);
      else if ($urandom_range(0, 3) == 0)
        retune(pick_width(), 1'($urandom));
      src_burst  = ($urandom_range(0, 4) == 0) && (run != PRESSURE_RUN);
      sink_burst = ($urandom_range(0, 4) == 0);
      if (run != PRESSURE_RUN && $urandom_range(0, 4) == 0)
        noise_run();
      else
        histogram_run(run == PRESSURE_RUN);
      run++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("linear_split_histogram_rebinner_unit_tb passed");
    else
      $display("linear_split_histogram_rebinner_unit_tb failed");
    $finish;
  end

endmodule
